/* hw/rtl/lobm_pkg.sv */
// Shared types and constants of the limit order book matcher.
package lobm_pkg;

    localparam int TICK_W       = 7;
    localparam int TICK_COUNT   = 128;
    localparam int LVL_W        = 8;
    localparam int LVL_COUNT    = 256;
    localparam int ID_W         = 12;
    localparam int MAX_ORDER_ID = 4095;
    localparam int QTY_W        = 32;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_LVL_FULL  = 2'd1;
    localparam logic [1:0] ST_IDS_GONE  = 2'd2;
    localparam logic [1:0] ST_CAN_REJ   = 2'd3;

    localparam logic MODE_ADD  = 1'b0;
    localparam logic MODE_CAN  = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct packed {
        logic              mode;
        logic              side;
        logic [TICK_W-1:0] price_tick;
        logic [QTY_W-1:0]  quantity;
        logic [ID_W-1:0]   cancel_id;
    } t_in;

    typedef struct packed {
        logic [1:0]        status;
        logic [ID_W-1:0]   order_id;
        logic [QTY_W-1:0]  filled_quantity;
        logic [QTY_W-1:0]  rested_quantity;
        logic [TICK_W-1:0] best_bid_tick;
        logic              bid_valid;
        logic [TICK_W-1:0] best_ask_tick;
        logic              ask_valid;
        logic signed [7:0] spread_ticks;
        logic              spread_valid;
    } t_out;

endpackage

/* hw/rtl/lobm_ram.sv */
// Simple dual-port synchronous RAM with registered read data.
module lobm_ram #(
    parameter int W  = 8,
    parameter int D  = 16,
    parameter int AW = 4
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end

endmodule

/* hw/rtl/lobm_prio.sv */
// Priority encoder over a tick occupancy map: lowest or highest set bit.
module lobm_prio #(
    parameter bit HIGH = 1'b0
) (
    input  logic [lobm_pkg::TICK_COUNT-1:0] i_map,
    output logic                            o_found,
    output logic [lobm_pkg::TICK_W-1:0]     o_tick
);

    always_comb begin
        o_found = 1'b0;
        o_tick  = '0;
        if (HIGH) begin
            for (int t = 0; t < lobm_pkg::TICK_COUNT; t++) begin
                if (i_map[t]) begin
                    o_found = 1'b1;
                    o_tick  = lobm_pkg::TICK_W'(t);
                end
            end
        end else begin
            for (int t = lobm_pkg::TICK_COUNT - 1; t >= 0; t--) begin
                if (i_map[t]) begin
                    o_found = 1'b1;
                    o_tick  = lobm_pkg::TICK_W'(t);
                end
            end
        end
    end

endmodule

/* hw/rtl/limit_order_book_matcher_core.sv */
// Top level of the limit order book matcher: sequencer, book memories and status.
//
// Two-sided book over 128 ticks with price-time matching. Raise start for one
// cycle while busy is low to hand in a word (add or cancel); busy then stays
// high until the result word has been produced. The result word appears on
// o_result for exactly one cycle with o_valid high and must be taken then:
// the receiver cannot stall it. The level entries, level pointers/counts and
// order locator live in three synchronous RAMs that are read, modified and
// written back one access per cycle; the occupancy maps and level valid flops
// are registers. A cancel reads the order locator, then tombstones the entry
// and updates its level's counts; a rejected cancel stops after the locator
// read, and an add rejected for lack of ids goes straight to the result. An
// add sweeps the price levels on the opposite side, reading each level's
// pointers and then its resting entries (tombstones included) in turn, and
// then rests any remainder. No clearing pass is needed after reset: levels carry valid flops
// and locator entries are trusted only for ids below the next id to issue.
module limit_order_book_matcher_core #(
    parameter int LEVEL_DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    input  lobm_pkg::t_in    i_item,
    output logic             busy,
    output logic             o_valid,
    output lobm_pkg::t_out   o_result
);

    localparam int SLOT_W = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
    localparam int CNT_W  = $clog2(LEVEL_DEPTH + 1);
    localparam int EADR_W = lobm_pkg::LVL_W + SLOT_W;
    localparam int ENT_W  = lobm_pkg::QTY_W + lobm_pkg::ID_W;
    localparam int META_W = 2 * SLOT_W + 2 * CNT_W;
    localparam int LOC_W  = 2 + lobm_pkg::TICK_W + SLOT_W;
    localparam int NID_W  = lobm_pkg::ID_W + 1;
    localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(LEVEL_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(LEVEL_DEPTH);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_SWEEP     = 10'b0000000010,
        S_META      = 10'b0000000100,
        S_ENT_RD    = 10'b0000001000,
        S_ENT       = 10'b0000010000,
        S_REST      = 10'b0000100000,
        S_REST_META = 10'b0001000000,
        S_CAN_LOC   = 10'b0010000000,
        S_CAN_META  = 10'b0100000000,
        S_FIN       = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    lobm_pkg::t_in r_in;
    logic [lobm_pkg::ID_W-1:0]  r_oid;
    logic [lobm_pkg::QTY_W-1:0] r_rem, r_filled, r_rested;
    logic [1:0]                 r_status;
    logic [lobm_pkg::LVL_W-1:0] r_lv;
    logic [SLOT_W-1:0]          r_head, r_tail;
    logic [CNT_W-1:0]           r_used, r_live;
    logic [NID_W-1:0]           r_next_id;
    logic [lobm_pkg::TICK_COUNT-1:0] r_bid_map, r_ask_map;
    logic [lobm_pkg::LVL_COUNT-1:0]  r_lvl_vld;

    // memory ports
    logic                        ent_we, meta_we, loc_we;
    logic [EADR_W-1:0]           ent_waddr, ent_raddr;
    logic [ENT_W-1:0]            ent_wdata, ent_rdata;
    logic [lobm_pkg::LVL_W-1:0]  meta_waddr, meta_raddr;
    logic [META_W-1:0]           meta_wdata, meta_rdata;
    logic [lobm_pkg::ID_W-1:0]   loc_waddr, loc_raddr;
    logic [LOC_W-1:0]            loc_wdata, loc_rdata;

    lobm_ram #(.W(ENT_W), .D(lobm_pkg::LVL_COUNT << SLOT_W), .AW(EADR_W)) u_ent (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );
    lobm_ram #(.W(META_W), .D(lobm_pkg::LVL_COUNT), .AW(lobm_pkg::LVL_W)) u_meta (
        .i_clk(i_clk), .i_we(meta_we), .i_waddr(meta_waddr), .i_wdata(meta_wdata),
        .i_raddr(meta_raddr), .o_rdata(meta_rdata)
    );
    lobm_ram #(.W(LOC_W), .D(lobm_pkg::MAX_ORDER_ID + 1), .AW(lobm_pkg::ID_W)) u_loc (
        .i_clk(i_clk), .i_we(loc_we), .i_waddr(loc_waddr), .i_wdata(loc_wdata),
        .i_raddr(loc_raddr), .o_rdata(loc_rdata)
    );

    // best bid / best ask from the occupancy maps
    logic bid_found, ask_found;
    logic [lobm_pkg::TICK_W-1:0] bid_tick, ask_tick;

    lobm_prio #(.HIGH(1'b1)) u_bid (.i_map(r_bid_map), .o_found(bid_found), .o_tick(bid_tick));
    lobm_prio #(.HIGH(1'b0)) u_ask (.i_map(r_ask_map), .o_found(ask_found), .o_tick(ask_tick));

    // decoded memory words
    logic [SLOT_W-1:0] m_head, m_tail;
    logic [CNT_W-1:0]  m_used, m_live;
    logic [lobm_pkg::QTY_W-1:0] e_qty, fill, e_left;
    logic [lobm_pkg::ID_W-1:0]  e_id;
    logic              l_vld, l_side;
    logic [lobm_pkg::TICK_W-1:0] l_tick;
    logic [SLOT_W-1:0] l_slot;
    logic              sweep_go, ent_more, lvl_dead, can_ok;
    logic [SLOT_W-1:0] head_inc, tail_inc;
    logic [lobm_pkg::LVL_W-1:0] sweep_lv;

    always_comb begin
        {m_head, m_tail, m_used, m_live} = r_lvl_vld[r_lv] ? meta_rdata : '0;
        {e_qty, e_id}                    = ent_rdata;
        {l_vld, l_side, l_tick, l_slot}  = loc_rdata;
        fill     = (e_qty < r_rem) ? e_qty : r_rem;
        e_left   = e_qty - fill;
        head_inc = (r_head == SLOT_LAST) ? '0 : r_head + 1'b1;
        tail_inc = (m_tail == SLOT_LAST) ? '0 : m_tail + 1'b1;
        if (r_in.side == lobm_pkg::SIDE_BUY) begin
            sweep_go = ask_found && (ask_tick <= r_in.price_tick);
            sweep_lv = {1'b1, ask_tick};
        end else begin
            sweep_go = bid_found && (bid_tick >= r_in.price_tick);
            sweep_lv = {1'b0, bid_tick};
        end
        sweep_go = sweep_go && (r_rem != '0);
        ent_more = (r_used != '0) && (r_rem != '0);
        lvl_dead = (r_live == '0) || (r_used == '0);
        can_ok   = l_vld && (r_in.cancel_id != '0) && ({1'b0, r_in.cancel_id} < r_next_id);
    end

    // memory addressing and next state
    always_comb begin
        n_state    = r_state;
        ent_we     = 1'b0;
        ent_waddr  = {r_lv, r_head};
        ent_wdata  = {e_left, e_id};
        ent_raddr  = {r_lv, r_head};
        meta_we    = 1'b0;
        meta_waddr = r_lv;
        meta_wdata = {r_head, r_tail, r_used, r_live};
        meta_raddr = r_lv;
        loc_we     = 1'b0;
        loc_waddr  = e_id;
        loc_wdata  = '0;
        loc_raddr  = (r_state == S_IDLE) ? i_item.cancel_id : r_in.cancel_id;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    if (i_item.mode == lobm_pkg::MODE_CAN) begin
                        n_state = S_CAN_LOC;
                    end else if (r_next_id > NID_W'(lobm_pkg::MAX_ORDER_ID)) begin
                        n_state = S_FIN;
                    end else begin
                        // mark the fresh id's locator empty before anything else
                        loc_we    = 1'b1;
                        loc_waddr = r_next_id[lobm_pkg::ID_W-1:0];
                        n_state   = S_SWEEP;
                    end
                end
            end
            S_SWEEP: begin
                meta_raddr = sweep_lv;
                n_state    = sweep_go ? S_META : S_REST;
            end
            S_META: begin
                n_state = S_ENT_RD;
            end
            S_ENT_RD: begin
                if (ent_more) begin
                    n_state = S_ENT;
                end else begin
                    meta_we = !lvl_dead;
                    n_state = S_SWEEP;
                end
            end
            S_ENT: begin
                if (e_id != '0) begin
                    ent_we = (e_left != '0);
                    loc_we = (e_left == '0);
                end
                n_state = S_ENT_RD;
            end
            S_REST: begin
                meta_raddr = {r_in.side, r_in.price_tick};
                n_state    = (r_rem == '0) ? S_FIN : S_REST_META;
            end
            S_REST_META: begin
                if (m_used < CNT_FULL) begin
                    ent_we     = 1'b1;
                    ent_waddr  = {r_lv, m_tail};
                    ent_wdata  = {r_rem, r_oid};
                    meta_we    = 1'b1;
                    meta_wdata = {m_head, tail_inc, m_used + 1'b1, m_live + 1'b1};
                    loc_we     = 1'b1;
                    loc_waddr  = r_oid;
                    loc_wdata  = {1'b1, r_in.side, r_in.price_tick, m_tail};
                end
                n_state = S_FIN;
            end
            S_CAN_LOC: begin
                meta_raddr = {l_side, l_tick};
                n_state    = can_ok ? S_CAN_META : S_FIN;
            end
            S_CAN_META: begin
                ent_we     = 1'b1;
                ent_waddr  = {r_lv, l_slot};
                ent_wdata  = '0;
                meta_we    = (m_live > CNT_W'(1));
                meta_wdata = {m_head, m_tail, m_used, m_live - 1'b1};
                loc_we     = 1'b1;
                loc_waddr  = r_in.cancel_id;
                n_state    = S_FIN;
            end
            S_FIN: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // clear a level's map bit and valid flop
    task automatic drop_level(input logic [lobm_pkg::LVL_W-1:0] lv);
        r_lvl_vld[lv] <= 1'b0;
        if (lv[lobm_pkg::LVL_W-1]) begin
            r_ask_map[lv[lobm_pkg::TICK_W-1:0]] <= 1'b0;
        end else begin
            r_bid_map[lv[lobm_pkg::TICK_W-1:0]] <= 1'b0;
        end
    endtask

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next_id <= NID_W'(1);
            r_bid_map <= '0;
            r_ask_map <= '0;
            r_lvl_vld <= '0;
            o_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            o_valid <= (r_state == S_FIN);
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_in     <= i_item;
                        r_oid    <= '0;
                        r_rem    <= i_item.quantity;
                        r_filled <= '0;
                        r_rested <= '0;
                        r_status <= lobm_pkg::ST_OK;
                        if (i_item.mode == lobm_pkg::MODE_ADD) begin
                            if (r_next_id > NID_W'(lobm_pkg::MAX_ORDER_ID)) begin
                                r_status <= lobm_pkg::ST_IDS_GONE;
                            end else begin
                                r_oid     <= r_next_id[lobm_pkg::ID_W-1:0];
                                r_next_id <= r_next_id + 1'b1;
                            end
                        end
                    end
                end
                S_SWEEP: begin
                    r_lv <= sweep_lv;
                end
                S_META: begin
                    r_head <= m_head;
                    r_tail <= m_tail;
                    r_used <= m_used;
                    r_live <= m_live;
                end
                S_ENT_RD: begin
                    if (!ent_more && lvl_dead) begin
                        drop_level(r_lv);
                    end
                end
                S_ENT: begin
                    if (e_id == '0) begin
                        r_head <= head_inc;
                        r_used <= r_used - 1'b1;
                    end else begin
                        r_rem    <= r_rem - fill;
                        r_filled <= r_filled + fill;
                        if (e_left == '0) begin
                            r_head <= head_inc;
                            r_used <= r_used - 1'b1;
                            if (r_live != '0) begin
                                r_live <= r_live - 1'b1;
                            end
                        end
                    end
                end
                S_REST: begin
                    r_lv <= {r_in.side, r_in.price_tick};
                end
                S_REST_META: begin
                    if (m_used < CNT_FULL) begin
                        r_rested       <= r_rem;
                        r_lvl_vld[r_lv] <= 1'b1;
                        if (r_in.side == lobm_pkg::SIDE_SELL) begin
                            r_ask_map[r_in.price_tick] <= 1'b1;
                        end else begin
                            r_bid_map[r_in.price_tick] <= 1'b1;
                        end
                    end else begin
                        r_status <= lobm_pkg::ST_LVL_FULL;
                    end
                end
                S_CAN_LOC: begin
                    r_lv <= {l_side, l_tick};
                    if (!can_ok) begin
                        r_status <= lobm_pkg::ST_CAN_REJ;
                    end
                end
                S_CAN_META: begin
                    if (m_live <= CNT_W'(1)) begin
                        drop_level(r_lv);
                    end
                end
                S_FIN: begin
                end
                default: begin
                end
            endcase
        end
    end

    // result word, built from the maps as they stand after the step
    always_ff @(posedge i_clk) begin
        if (r_state == S_FIN) begin
            o_result.status          <= r_status;
            o_result.order_id        <= r_oid;
            o_result.filled_quantity <= r_filled;
            o_result.rested_quantity <= r_rested;
            o_result.best_bid_tick   <= bid_found ? bid_tick : '0;
            o_result.bid_valid       <= bid_found;
            o_result.best_ask_tick   <= ask_found ? ask_tick : '0;
            o_result.ask_valid       <= ask_found;
            o_result.spread_ticks    <= (bid_found && ask_found) ?
                                        ({1'b0, ask_tick} - {1'b0, bid_tick}) : '0;
            o_result.spread_valid    <= bid_found && ask_found;
        end
    end

    assign busy = (r_state != S_IDLE);

    // a word is accepted only when idle, and the sequencer leaves idle at once
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // the result strobe never overlaps work in flight
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // ids only move forward
    a_id_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_next_id >= $past(r_next_id)))
        else $error("next order id went backward");

    // entry RAM is written only in the states that own it
    a_ent_we: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ent_we |-> (r_state == S_ENT || r_state == S_REST_META || r_state == S_CAN_META))
        else $error("entry write outside its states");

endmodule
